>>> hw/rtl/mitp_pkg.sv
`timescale 1ns / 1ps

package mitp_pkg;

   // Image geometry
   localparam int WORD_BITS = 16;
   localparam int ROW_COUNT = 65536;

   localparam int BitCntW = $clog2(WORD_BITS + 1);
   localparam int RowCntW = $clog2(ROW_COUNT + 1);

   // Result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_ROWS    = 3'd1;
   localparam logic [2:0] ERR_COLUMNS = 3'd2;
   localparam logic [2:0] ERR_SHORT   = 3'd3;
   localparam logic [2:0] ERR_NO_DATA = 3'd4;

   // Characters of the image text
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_ONE     = 8'h31;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // Response queue geometry
   localparam int FifoDepth = 4;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [15:0] row_index;
      logic [15:0] word_ones;
      logic [15:0] word_unknown;
      logic        last_of_run;
   } rsp_type;

   // Results produced by one character: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

>>> hw/rtl/mitp_parser.sv
`timescale 1ns / 1ps

module mitp_parser import mitp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  item,
   output emit_type emit
);

   logic                 comment_on_ff, comment_on_in;
   logic                 bits_seen_ff, bits_seen_in;
   logic [BitCntW-1:0]   bit_count_ff, bit_count_in;
   logic [RowCntW-1:0]   row_count_ff, row_count_in;
   logic [WORD_BITS-1:0] ones_shift_ff, ones_shift_in;
   logic [WORD_BITS-1:0] unknown_shift_ff, unknown_shift_in;
   logic                 halted_ff, halted_in;

   logic    line_valid, eof_valid;
   rsp_type line_rsp, eof_rsp;
   logic    is_data_char;

   assign is_data_char = (item.char_code == CHAR_ZERO) || (item.char_code == CHAR_ONE) ||
                         (item.char_code == CHAR_X);

   always_comb begin
      comment_on_in    = comment_on_ff;
      bits_seen_in     = bits_seen_ff;
      bit_count_in     = bit_count_ff;
      row_count_in     = row_count_ff;
      ones_shift_in    = ones_shift_ff;
      unknown_shift_in = unknown_shift_ff;
      halted_in        = halted_ff;
      line_valid       = 1'b0;
      eof_valid        = 1'b0;
      line_rsp         = '0;
      eof_rsp          = '0;
      line_rsp.row_index = 16'(row_count_ff);

      if (!halted_ff) begin
         if (item.end_of_file || (item.char_code == CHAR_NEWLINE)) begin
            // close the current line
            if (bits_seen_ff) begin
               line_valid = 1'b1;
               if (bit_count_ff != BitCntW'(WORD_BITS)) begin
                  line_rsp.kind       = KIND_ERROR;
                  line_rsp.error_code = ERR_SHORT;
                  halted_in           = 1'b1;
               end else begin
                  line_rsp.kind         = KIND_DATA;
                  line_rsp.word_ones    = 16'(ones_shift_ff);
                  line_rsp.word_unknown = 16'(unknown_shift_ff);
                  row_count_in          = row_count_ff + RowCntW'(1);
               end
            end
            if (!halted_in && item.end_of_file) begin
               eof_valid = 1'b1;
               halted_in = 1'b1;
               if (row_count_in == '0) begin
                  eof_rsp.kind       = KIND_ERROR;
                  eof_rsp.error_code = ERR_NO_DATA;
               end else begin
                  eof_rsp.kind      = KIND_END;
                  eof_rsp.row_index = 16'(row_count_in);
               end
            end
            comment_on_in    = 1'b0;
            bits_seen_in     = 1'b0;
            bit_count_in     = '0;
            ones_shift_in    = '0;
            unknown_shift_in = '0;
         end else if (!comment_on_ff) begin
            if (item.char_code == CHAR_SLASH) begin
               comment_on_in = 1'b1;
            end else if (is_data_char) begin
               bits_seen_in = 1'b1;
               if (row_count_ff >= RowCntW'(ROW_COUNT)) begin
                  line_valid          = 1'b1;
                  line_rsp.kind       = KIND_ERROR;
                  line_rsp.error_code = ERR_ROWS;
                  halted_in           = 1'b1;
               end else if (bit_count_ff >= BitCntW'(WORD_BITS)) begin
                  line_valid          = 1'b1;
                  line_rsp.kind       = KIND_ERROR;
                  line_rsp.error_code = ERR_COLUMNS;
                  halted_in           = 1'b1;
               end else begin
                  ones_shift_in    = (ones_shift_ff << 1) |
                                     WORD_BITS'(item.char_code == CHAR_ONE);
                  unknown_shift_in = (unknown_shift_ff << 1) |
                                     WORD_BITS'(item.char_code == CHAR_X);
                  bit_count_in     = bit_count_ff + BitCntW'(1);
               end
            end
         end
      end
   end

   // pack: the line result always comes first
   always_comb begin
      emit = '0;
      if (line_valid) begin
         emit.first             = line_rsp;
         emit.first.last_of_run = !eof_valid;
         emit.second            = eof_rsp;
         emit.second.last_of_run = 1'b1;
         emit.count             = eof_valid ? 2'd2 : 2'd1;
      end else if (eof_valid) begin
         emit.first             = eof_rsp;
         emit.first.last_of_run = 1'b1;
         emit.count             = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_on_ff    <= 1'b0;
         bits_seen_ff     <= 1'b0;
         bit_count_ff     <= '0;
         row_count_ff     <= '0;
         ones_shift_ff    <= '0;
         unknown_shift_ff <= '0;
         halted_ff        <= 1'b0;
      end else if (fire) begin
         comment_on_ff    <= comment_on_in;
         bits_seen_ff     <= bits_seen_in;
         bit_count_ff     <= bit_count_in;
         row_count_ff     <= row_count_in;
         ones_shift_ff    <= ones_shift_in;
         unknown_shift_ff <= unknown_shift_in;
         halted_ff        <= halted_in;
      end
   end

endmodule

>>> hw/rtl/mitp_rsp_fifo.sv
`timescale 1ns / 1ps

module mitp_rsp_fifo import mitp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  emit_type emit,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type             mem_ff [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0] count_ff, count_in;
   logic                pop;
   logic [1:0]          push_n;

   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = push ? emit.count : 2'd0;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // leave space for the worst case of two results
   assign room      = (count_ff <= FifoCntW'(FifoDepth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + FifoPtrW'(pop);
      count_in  = count_ff + FifoCntW'(push_n) - FifoCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= emit.first;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + FifoPtrW'(1)] <= emit.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/memory_image_text_parser.sv
`timescale 1ns / 1ps

// channel  direction  word      handshake
// req_     in         req_type  req_valid / req_ready, one character or end of file
// rsp_     out        rsp_type  rsp_valid / rsp_ready, data word, end or error
//
// One character is taken per cycle while the response queue has room.
// A result reaches rsp_ after its character is accepted, by way of the input
// register and then the response queue.
// Parse the held character only while the four-word queue has room for two words.
// Reset clears the parser state and the queue at once; no clearing pass.
// A stalled rsp_ side fills the queue, then the input register, then drops req_ready.

module memory_image_text_parser import mitp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     room;
   logic     consume;
   logic     req_fire;
   emit_type emit;

   // parse the held character once the queue can take its results
   assign consume   = in_valid_ff && room;
   // take a new character whenever the input register frees up this cycle
   assign req_ready = !in_valid_ff || consume;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload; no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   // advance the line and row state, build zero to two results
   mitp_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (consume),
      .item  (in_data_ff),
      .emit  (emit)
   );

   // queue results so a stalled consumer does not stop the parser at once
   mitp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (consume),
      .emit      (emit),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/image_word_tracker.sv
`timescale 1ns / 1ps

module image_word_tracker import mitp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   logic                 comment_on;
   logic                 bits_seen;
   logic [BitCntW-1:0]   bit_count;
   logic [RowCntW-1:0]   row_count;
   logic [WORD_BITS-1:0] ones_shift;
   logic [WORD_BITS-1:0] unknown_shift;
   logic                 halted;
   rsp_type              parsed_words [$];
   int                   failures = 0;

   // row_index always carries the rows delivered so far
   function automatic rsp_type make_word(input logic [1:0] kind, input logic [2:0] code,
                                         input logic [15:0] ones, input logic [15:0] unknown);
      rsp_type w;
      w.kind         = kind;
      w.error_code   = code;
      w.row_index    = 16'(row_count);
      w.word_ones    = ones;
      w.word_unknown = unknown;
      w.last_of_run  = 1'b0;
      return w;
   endfunction

   task automatic clear_line();
      comment_on    = 1'b0;
      bits_seen     = 1'b0;
      bit_count     = '0;
      ones_shift    = '0;
      unknown_shift = '0;
   endtask

   task automatic parse_character(input req_type w);
      rsp_type produced [2];
      int      n;
      logic    is_bit;
      n      = 0;
      is_bit = (w.char_code == CHAR_ZERO) || (w.char_code == CHAR_ONE) ||
               (w.char_code == CHAR_X);
      if (halted) return;
      if (w.end_of_file || w.char_code == CHAR_NEWLINE) begin
         if (bits_seen) begin
            if (bit_count != WORD_BITS) begin
               produced[n++] = make_word(KIND_ERROR, ERR_SHORT, '0, '0);
               halted = 1'b1;
            end else begin
               produced[n++] = make_word(KIND_DATA, ERR_NONE, 16'(ones_shift),
                                         16'(unknown_shift));
               row_count++;
            end
         end
         if (!halted && w.end_of_file) begin
            if (row_count == 0) produced[n++] = make_word(KIND_ERROR, ERR_NO_DATA, '0, '0);
            else produced[n++] = make_word(KIND_END, ERR_NONE, '0, '0);
            halted = 1'b1;
         end
         clear_line();
      end else if (!comment_on) begin
         if (w.char_code == CHAR_SLASH) begin
            comment_on = 1'b1;
         end else if (is_bit) begin
            bits_seen = 1'b1;
            if (row_count >= ROW_COUNT) begin
               produced[n++] = make_word(KIND_ERROR, ERR_ROWS, '0, '0);
               halted = 1'b1;
            end else if (bit_count >= WORD_BITS) begin
               produced[n++] = make_word(KIND_ERROR, ERR_COLUMNS, '0, '0);
               halted = 1'b1;
            end else begin
               ones_shift    = (ones_shift << 1) | WORD_BITS'(w.char_code == CHAR_ONE);
               unknown_shift = (unknown_shift << 1) | WORD_BITS'(w.char_code == CHAR_X);
               bit_count++;
            end
         end
      end
      if (n > 0) produced[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) parsed_words.push_back(produced[i]);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_line();
         row_count = '0;
         halted    = 1'b0;
         parsed_words.delete();
      end else begin
         if (req_valid && req_ready) parse_character(req_data);
         if (rsp_valid && rsp_ready) begin
            if (parsed_words.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, actual %h", $time, rsp_data);
               failures++;
            end else begin
               want = parsed_words.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_data.kind));
               check_field("error_code", 16'(want.error_code), 16'(rsp_data.error_code));
               check_field("row_index", want.row_index, rsp_data.row_index);
               check_field("word_ones", want.word_ones, rsp_data.word_ones);
               check_field("word_unknown", want.word_unknown, rsp_data.word_unknown);
               check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_data.last_of_run));
            end
         end
      end
      fail_count    <= failures;
      pending_count <= parsed_words.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mitp_pkg::*;

   // How the image text is closed; one terminal event per run, since the
   // block halts for good after its end or error word.
   typedef enum int {
      END_AFTER_WORD,
      END_AFTER_NEWLINE,
      END_SHORT_NEWLINE,
      END_SHORT_EOF,
      END_COLUMNS,
      END_NO_DATA
   } image_end_type;

   localparam int TEXT_ITEMS   = 600;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   // Sender state: burst length, character count
   int            burst_left  = 1;
   int            items_sent  = 0;
   image_end_type closing;

   // Receiver pattern state
   int stall_period = 4;
   int stall_len    = 0;
   int stall_phase  = 0;
   int pattern_left = 0;
   int idle_cycles  = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   memory_image_text_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   image_word_tracker tracker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Drop rsp_ready while stall_phase, wrapping at stall_period, is below
   // stall_len; pick a new pattern now and then, sometimes one with no stall.
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(50, 400);
         stall_period = $urandom_range(2, 16);
         stall_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      end else begin
         pattern_left--;
      end
      stall_phase = (stall_phase + 1) % stall_period;
      rsp_ready <= (stall_phase >= stall_len);
   end

   // Watchdog: end the run if no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one word and hold it until accepted; then maybe close the burst
   // and idle for a random gap.
   task automatic send_item(input logic [7:0] code, input logic eof);
      req_valid <= 1'b1;
      req_data  <= '{char_code: code, end_of_file: eof};
      do @(posedge clock); while (!req_ready);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
   endtask

   function automatic logic [7:0] pick_filler();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c inside {CHAR_SLASH, CHAR_ZERO, CHAR_ONE, CHAR_X, CHAR_NEWLINE});
      return c;
   endfunction

   function automatic logic [7:0] pick_bit_char();
      case ($urandom_range(0, 2))
         0:       return CHAR_ZERO;
         1:       return CHAR_ONE;
         default: return CHAR_X;
      endcase
   endfunction

   function automatic logic [WORD_BITS-1:0] random_bits();
      return WORD_BITS'({$urandom, $urandom});
   endfunction

   // Vary the density of don't-care bits, all-x lines included
   function automatic logic [WORD_BITS-1:0] random_unknown();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return random_bits() & random_bits() & random_bits();
         2:       return '1;
         default: return random_bits();
      endcase
   endfunction

   // Send the top count bits of a word, MSB first; an 'x' wins over '1'.
   // Noisy lines carry ignored characters between the bits.
   task automatic send_bits(input logic [WORD_BITS-1:0] ones,
                            input logic [WORD_BITS-1:0] unknown,
                            input int count, input logic noisy);
      for (int i = WORD_BITS - 1; i >= WORD_BITS - count; i--) begin
         if (noisy && $urandom_range(0, 3) == 0) send_item(pick_filler(), 1'b0);
         send_item(unknown[i] ? CHAR_X : (ones[i] ? CHAR_ONE : CHAR_ZERO), 1'b0);
      end
   endtask

   // A comment that hides data characters and slashes; never a newline
   task automatic send_comment(input int len);
      logic [7:0] c;
      send_item(CHAR_SLASH, 1'b0);
      repeat (len) begin
         c = ($urandom_range(0, 1) == 0) ? pick_bit_char() : 8'($urandom_range(0, 255));
         send_item((c == CHAR_NEWLINE) ? CHAR_SLASH : c, 1'b0);
      end
   endtask

   task automatic send_row(input logic noisy, input logic tail_comment);
      send_bits(random_bits(), random_unknown(), WORD_BITS, noisy);
      if (tail_comment) send_comment($urandom_range(0, 8));
      send_item(CHAR_NEWLINE, 1'b0);
   endtask

   initial begin
      closing = image_end_type'($urandom_range(0, 5));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored byte extremes, a full line of every bit character
      // unless no data is chosen, a comment line hiding data, an empty line.
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      if (closing != END_NO_DATA) begin
         send_bits(WORD_BITS'(16'h8001), WORD_BITS'(16'h4002), WORD_BITS, 1'b0);
         send_item(CHAR_NEWLINE, 1'b0);
      end
      send_item(CHAR_SLASH, 1'b0);
      send_item(CHAR_ONE, 1'b0);
      send_item(CHAR_X, 1'b0);
      send_item(CHAR_SLASH, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);
      send_item(CHAR_NEWLINE, 1'b0);

      // Random text: mostly well-formed rows, with comment and noise lines.
      // Before its end of file, a "no data" run sends no bit outside a comment.
      while (items_sent < TEXT_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               send_comment($urandom_range(0, 12));
               send_item(CHAR_NEWLINE, 1'b0);
            end
            1: begin
               repeat ($urandom_range(0, 3)) send_item(pick_filler(), 1'b0);
               send_item(CHAR_NEWLINE, 1'b0);
            end
            default: begin
               if (closing == END_NO_DATA) begin
                  send_comment($urandom_range(0, 20));
                  send_item(CHAR_NEWLINE, 1'b0);
               end else begin
                  send_row($urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
               end
            end
         endcase
      end

      // Close the image with the chosen terminal case
      case (closing)
         END_AFTER_WORD: begin
            send_bits(random_bits(), random_unknown(), WORD_BITS, 1'b1);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_AFTER_NEWLINE: begin
            send_comment($urandom_range(0, 6));
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_SHORT_NEWLINE: begin
            send_bits(random_bits(), random_unknown(), $urandom_range(1, WORD_BITS - 1), 1'b1);
            send_item(CHAR_NEWLINE, 1'b0);
         end
         END_SHORT_EOF: begin
            send_bits(random_bits(), random_unknown(), $urandom_range(1, WORD_BITS - 1), 1'b1);
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
         END_COLUMNS: begin
            send_bits(random_bits(), random_unknown(), WORD_BITS, 1'b1);
            send_item(pick_bit_char(), 1'b0);
         end
         default: begin
            // no data anywhere: end of file alone
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase

      // The block is halted now: these words must give no result
      repeat (12) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;

      // Let pending_count take in the last word, then drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/mitp_pkg.sv
hw/rtl/mitp_parser.sv
hw/rtl/mitp_rsp_fifo.sv
hw/rtl/memory_image_text_parser.sv
tb/image_word_tracker.sv
tb/testbench.sv
